>>> hdl/rmst_pkg.sv
`default_nettype none

package rmst_pkg;

  // Field widths of one transaction
  localparam int POS_W     = 11;
  localparam int IN_VAL_W  = 31;
  localparam int OUT_W     = 31;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 32;

  // Bit offsets inside in_tdata
  localparam int POS_LSB   = 0;
  localparam int VAL_LSB   = POS_LSB + POS_W;
  localparam int FIRST_LSB = VAL_LSB + IN_VAL_W;
  localparam int LAST_LSB  = FIRST_LSB + POS_W;

  // Configuration space
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 1'b0;
  localparam logic [POS_W-1:0] ELEMENT_COUNT_RESET = 11'd1024;

  // Operation codes carried on in_tuser
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_U_CHECK,
    ST_U_LEAF,
    ST_U_READ,
    ST_U_PARENT,
    ST_Q_CHECK,
    ST_Q_READ,
    ST_Q_FOLD,
    ST_Q_EMIT
  } step_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_LOAD,
    ACT_WRITE_LEAF,
    ACT_READ_SIB,
    ACT_WRITE_PARENT,
    ACT_READ_PAIR,
    ACT_FOLD
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_CLR_MORE,
    C_NO_VALID,
    C_IS_QUERY,
    C_UPD_BAD,
    C_PARENT_NOT_ROOT,
    C_Q_EMPTY,
    C_LO_LT_HI,
    C_OUT_BUSY
  } cond_t;

  // One control word: datapath action, emit flag, jump condition, jump target, end of routine
  typedef struct packed {
    act_t  act;
    logic  emit;
    cond_t cond;
    step_t target;
    logic  last;
  } uword_t;

  // Datapath flags tested by the sequencer
  typedef struct packed {
    logic clr_more;
    logic in_valid;
    logic is_query;
    logic upd_bad;
    logic parent_not_root;
    logic q_empty;
    logic lo_lt_hi;
    logic out_busy;
  } status_t;

  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    begin
      w = '{act: ACT_NONE, emit: 1'b0, cond: C_NEVER, target: ST_IDLE, last: 1'b1};
      unique case (s)
        ST_CLEAR:    w = '{ACT_CLEAR,        1'b0, C_CLR_MORE,        ST_CLEAR,  1'b0};
        ST_IDLE:     w = '{ACT_LOAD,         1'b0, C_NO_VALID,        ST_IDLE,   1'b0};
        ST_DISPATCH: w = '{ACT_NONE,         1'b0, C_IS_QUERY,        ST_Q_CHECK, 1'b0};
        ST_U_CHECK:  w = '{ACT_NONE,         1'b0, C_UPD_BAD,         ST_IDLE,   1'b0};
        ST_U_LEAF:   w = '{ACT_WRITE_LEAF,   1'b0, C_NEVER,           ST_IDLE,   1'b0};
        ST_U_READ:   w = '{ACT_READ_SIB,     1'b0, C_NEVER,           ST_IDLE,   1'b0};
        ST_U_PARENT: w = '{ACT_WRITE_PARENT, 1'b0, C_PARENT_NOT_ROOT, ST_U_READ, 1'b1};
        ST_Q_CHECK:  w = '{ACT_NONE,         1'b0, C_Q_EMPTY,         ST_Q_EMIT, 1'b0};
        ST_Q_READ:   w = '{ACT_READ_PAIR,    1'b0, C_NEVER,           ST_IDLE,   1'b0};
        ST_Q_FOLD:   w = '{ACT_FOLD,         1'b0, C_LO_LT_HI,        ST_Q_READ, 1'b0};
        ST_Q_EMIT:   w = '{ACT_NONE,         1'b1, C_OUT_BUSY,        ST_Q_EMIT, 1'b1};
        default:     w = '{ACT_NONE,         1'b0, C_NEVER,           ST_IDLE,   1'b1};
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/rmst_useq.sv
`default_nettype none

module rmst_useq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rmst_pkg::status_t stat,
  output rmst_pkg::uword_t      ctrl
);
  import rmst_pkg::*;

  step_t  upc_r;
  step_t  upc_nxt;
  uword_t cw;
  logic   take;

  assign cw = ucode_rom(upc_r);

  always_comb begin
    case (cw.cond)
      C_NEVER:           take = 1'b0;
      C_CLR_MORE:        take = stat.clr_more;
      C_NO_VALID:        take = !stat.in_valid;
      C_IS_QUERY:        take = stat.is_query;
      C_UPD_BAD:         take = stat.upd_bad;
      C_PARENT_NOT_ROOT: take = stat.parent_not_root;
      C_Q_EMPTY:         take = stat.q_empty;
      C_LO_LT_HI:        take = stat.lo_lt_hi;
      C_OUT_BUSY:        take = stat.out_busy;
      default:           take = 1'b0;
    endcase
  end

  // Next step: jump, end of routine back to idle, or advance
  always_comb begin
    if (take) begin
      upc_nxt = cw.target;
    end else if (cw.last) begin
      upc_nxt = ST_IDLE;
    end else begin
      upc_nxt = step_t'(upc_r + 4'd1);
    end
  end

  always_comb begin
    ctrl = cw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_CLEAR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  a_clear_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == ST_CLEAR && !stat.clr_more) |=> (upc_r == ST_IDLE))
    else $error("clear pass did not hand over to idle");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == ST_IDLE && !stat.in_valid) |=> (upc_r == ST_IDLE))
    else $error("sequencer left idle without a transaction");

endmodule

`default_nettype wire

>>> hdl/rmst_datapath.sv
`default_nettype none

module rmst_datapath #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 31
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rmst_pkg::uword_t                ctrl,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tuser,
  input  wire logic [rmst_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [rmst_pkg::POS_W-1:0]      used_cnt,
  input  wire logic                            out_tready,
  output logic                                 out_tvalid,
  output logic [rmst_pkg::OUT_W-1:0]           out_max,
  output rmst_pkg::status_t                    status
);
  import rmst_pkg::*;

  localparam int NODE_W = $clog2(2 * CAPACITY);
  localparam int HI_W   = NODE_W + 1;
  localparam int DEPTH  = 2 * CAPACITY;
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(DEPTH - 1);
  localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'(CAPACITY);
  localparam logic [HI_W-1:0]   HI_BASE   = HI_W'(CAPACITY);

  logic [VALUE_BITS-1:0] mem [DEPTH];

  logic [POS_W-1:0]      f_pos, f_first, f_last, first_c, last_c;
  logic [IN_VAL_W-1:0]   f_val;
  logic                  accept;

  logic                  op_r, upd_ok_r, q_empty_r, out_valid_r;
  logic [NODE_W-1:0]     node_r, clr_idx_r, parent;
  logic [HI_W-1:0]       lo_r, hi_r, lo_fold, hi_fold;
  logic [VALUE_BITS-1:0] cur_r, best_r, rd0_r, rd1_r;
  logic [VALUE_BITS-1:0] par_max, c0, c1, pair_max, best_fold;
  logic [OUT_W-1:0]      out_max_r;

  logic                  we;
  logic [NODE_W-1:0]     wa, ra0, ra1;
  logic [VALUE_BITS-1:0] wd;

  assign f_pos   = in_tdata[POS_LSB +: POS_W];
  assign f_val   = in_tdata[VAL_LSB +: IN_VAL_W];
  assign f_first = in_tdata[FIRST_LSB +: POS_W];
  assign f_last  = in_tdata[LAST_LSB +: POS_W];

  // Clip the query range to the positions in use
  assign first_c = (f_first == '0) ? POS_W'(1) : f_first;
  assign last_c  = (f_last > used_cnt) ? used_cnt : f_last;

  assign accept = (ctrl.act == ACT_LOAD) && in_tvalid;

  assign parent  = node_r >> 1;
  assign par_max = (rd0_r > cur_r) ? rd0_r : cur_r;

  assign c0        = lo_r[0] ? rd0_r : '0;
  assign c1        = hi_r[0] ? rd1_r : '0;
  assign pair_max  = (c0 > c1) ? c0 : c1;
  assign best_fold = (pair_max > best_r) ? pair_max : best_r;
  assign lo_fold   = (lo_r + HI_W'(lo_r[0])) >> 1;
  assign hi_fold   = hi_r >> 1;

  assign ra0 = (ctrl.act == ACT_READ_SIB) ? (node_r ^ NODE_W'(1)) : lo_r[NODE_W-1:0];
  assign ra1 = NODE_W'(hi_r - HI_W'(1));

  always_comb begin
    we = 1'b0;
    wa = node_r;
    wd = cur_r;
    case (ctrl.act)
      ACT_CLEAR: begin
        we = 1'b1;
        wa = clr_idx_r;
        wd = '0;
      end
      ACT_WRITE_LEAF: begin
        we = 1'b1;
      end
      ACT_WRITE_PARENT: begin
        we = 1'b1;
        wa = parent;
        wd = par_max;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.clr_more        = (clr_idx_r != LAST_NODE);
    status.in_valid        = in_tvalid;
    status.is_query        = (op_r == OP_QUERY);
    status.upd_bad         = !upd_ok_r;
    status.parent_not_root = (parent != NODE_W'(1));
    status.q_empty         = q_empty_r;
    status.lo_lt_hi        = (lo_fold < hi_fold);
    status.out_busy        = out_valid_r && !out_tready;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.act == ACT_CLEAR) begin
        clr_idx_r <= clr_idx_r + NODE_W'(1);
      end
      if (ctrl.emit && !status.out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_tuser;
      upd_ok_r  <= (f_pos != '0) && (f_pos <= used_cnt);
      node_r    <= LEAF_BASE + NODE_W'(f_pos) - NODE_W'(1);
      cur_r     <= VALUE_BITS'(f_val);
      q_empty_r <= (first_c > last_c);
      lo_r      <= HI_BASE + HI_W'(first_c) - HI_W'(1);
      hi_r      <= HI_BASE + HI_W'(last_c);
      best_r    <= '0;
    end
    if (ctrl.act == ACT_WRITE_PARENT) begin
      node_r <= parent;
      cur_r  <= par_max;
    end
    if (ctrl.act == ACT_FOLD) begin
      best_r <= best_fold;
      lo_r   <= lo_fold;
      hi_r   <= hi_fold;
    end
    if (ctrl.emit && !status.out_busy) begin
      out_max_r <= OUT_W'(best_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_max    = out_max_r;

  a_fold_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.act == ACT_FOLD) |-> (lo_r < hi_r))
    else $error("query walk folded with an empty window");

  a_parent_above_root: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.act == ACT_WRITE_PARENT) |-> (node_r > NODE_W'(1)))
    else $error("update walk climbed past the root");

  a_leaf_in_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.act == ACT_WRITE_LEAF) |-> (node_r >= LEAF_BASE))
    else $error("leaf write aimed at an inner node");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.emit && !status.out_busy) |=> out_tvalid)
    else $error("emitted result not presented");

endmodule

`default_nettype wire

>>> hdl/range_max_segment_tree_unit.sv
`default_nettype none
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready  tdata: position, new_value, range_first, range_last
//                                    tuser: operation (0 update, 1 query)
// out_     out  out_tvalid/out_tready tdata: range_maximum
// cfg_     in   APB psel/penable     register 0 at 0x0: element_count
//
// After reset a clear pass writes zero to all 2*CAPACITY tree nodes, one per cycle;
// in_tready stays low during the clear pass; config writes are taken throughout.
// Update: a check, the leaf write, then one sibling read and one parent write per level
// through the single write port; a rejected position goes back to idle after the check.
// Query: a check, then for each level walked (at most log2(CAPACITY) + 1) a two-port
// read then a fold, then the emit step; an empty range goes from the check to emit.
// One transaction at a time; in_tready is high only while the sequencer idles.
// A held result (out_tready low) stalls only the next query at its emit step.

module range_max_segment_tree_unit #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 31
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [10:0] position, [41:11] new_value, [52:42] range_first, [63:53] range_last
  input  wire logic [rmst_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] operation
  input  wire logic                              in_tuser,
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [30:0] range_maximum, [31] zero
  output logic [rmst_pkg::OUT_DATA_W-1:0]        out_tdata,
  // configuration port
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [rmst_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [rmst_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [rmst_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                   cfg_pready
);
  import rmst_pkg::*;

  // Largest count the 11-bit register can reach that the tree still covers
  localparam logic [POS_W-1:0] CAP_CLIP =
    POS_W'((CAPACITY > 2047) ? 2047 : CAPACITY);

  logic [POS_W-1:0]     elem_cnt_r;
  logic [POS_W-1:0]     used_cnt;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;
  uword_t               ctrl;
  status_t              stat;
  logic [OUT_W-1:0]     out_max;

  // Word index: drop the byte offset
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_cnt_r <= ELEMENT_COUNT_RESET;
    end else if (cfg_wr && (cfg_idx == REG_ELEMENT_COUNT)) begin
      elem_cnt_r <= cfg_pwdata[POS_W-1:0];
    end
  end

  always_comb begin
    if (cfg_idx == REG_ELEMENT_COUNT) begin
      cfg_prdata = CFG_DATA_W'(elem_cnt_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  // Counts above the tree size act as the tree size
  assign used_cnt = (elem_cnt_r > CAP_CLIP) ? CAP_CLIP : elem_cnt_r;

  rmst_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  rmst_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .used_cnt   (used_cnt),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_max    (out_max),
    .status     (stat)
  );

  // Take a transaction only at the idle step
  assign in_tready = (ctrl.act == ACT_LOAD);
  assign out_tdata = OUT_DATA_W'(out_max);

endmodule

`default_nettype wire

>>> tb/range_max_tracker_pkg.sv
`timescale 1ns / 100ps

package range_max_tracker_pkg;
  import rmst_pkg::*;

  localparam int LEAF_COUNT = 1024;

  class range_max_tracker;
    logic [OUT_W-1:0] leaf_value [1:LEAF_COUNT];
    logic [POS_W-1:0] element_count;
    logic [OUT_W-1:0] pending_maxima [$];
    int unsigned      error_count;

    function new();
      foreach (leaf_value[i]) leaf_value[i] = '0;
      element_count = ELEMENT_COUNT_RESET;
      error_count   = 0;
    endfunction

    function void set_count(logic [POS_W-1:0] count);
      element_count = count;
    endfunction

    // counts above the leaf count act as the leaf count
    function int unsigned positions_in_use();
      return (element_count > LEAF_COUNT) ? LEAF_COUNT : int'(element_count);
    endfunction

    function int unsigned pending();
      return pending_maxima.size();
    endfunction

    // scan the leaves directly instead of walking a tree
    function logic [OUT_W-1:0] clipped_range_max(int unsigned first, int unsigned last);
      logic [OUT_W-1:0] best;
      int unsigned      top;
      best = '0;
      top  = positions_in_use();
      if (first < 1) first = 1;
      if (last > top) last = top;
      for (int unsigned p = first; p <= last; p++)
        if (leaf_value[p] > best) best = leaf_value[p];
      return best;
    endfunction

    function void take_item(logic op, logic [POS_W-1:0] pos, logic [IN_VAL_W-1:0] val,
                            logic [POS_W-1:0] first, logic [POS_W-1:0] last);
      if (op == OP_UPDATE) begin
        if (pos >= 1 && pos <= positions_in_use()) leaf_value[pos] = val;
      end else begin
        pending_maxima.push_back(clipped_range_max(first, last));
      end
    endfunction

    function void match_maximum(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (pending_maxima.size() == 0) begin
        $display("%0t: unexpected range_maximum %0d with no query outstanding", $time, got);
        error_count++;
        return;
      end
      want = pending_maxima.pop_front();
      if (got !== want) begin
        $display("%0t: range_maximum mismatch, expected %0d, actual %0d", $time, want, got);
        error_count++;
      end
    endfunction
  endclass

endpackage

>>> tb/range_max_segment_tree_unit_test.sv
`timescale 1ns / 100ps

module range_max_segment_tree_unit_test;
  import rmst_pkg::*;
  import range_max_tracker_pkg::*;

  localparam int POS_ALL       = 2**POS_W - 1;
  // an update gives no result; wait for it to finish before config
  localparam int SETTLE_CYCLES = 40;
  // clear pass, ~1400 transactions at worst-case gap, stall and latency, many times over
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 170;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [10:0] position, [41:11] new_value, [52:42] range_first, [63:53] range_last
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // [0] operation
  logic                  in_tuser = OP_UPDATE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [30:0] range_maximum, [31] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  range_max_tracker tracker = new;

  // sender and receiver pacing
  bit          idle_on = 1'b1;
  int unsigned burst_left = 0;
  int unsigned ready_hold = 0;
  int unsigned cycle_count = 0;

  range_max_segment_tree_unit #(
    .CAPACITY  (LEAF_COUNT),
    .VALUE_BITS(IN_VAL_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: hold tready at a random level for a random run of cycles; mostly short
  // runs, now and then a long one. With idling off, keep it high.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!idle_on) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 2) != 0);
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 4);
    end
  end

  // Check every result transaction against the oldest outstanding query.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.match_maximum(out_tdata[OUT_W-1:0]);
  end

  // Watchdog: give up on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One APB transfer to the element_count register. Leave psel high at the end so a
  // second transfer can follow back to back; the caller drops it.
  task automatic cfg_transfer(input logic wr, input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {REG_ELEMENT_COUNT, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
  endtask

  // Present one input transaction; when the current burst is used up, open a new one after a
  // random gap unless idling is off, and keep tvalid high inside a burst.
  task automatic send_item(input logic op, input logic [POS_W-1:0] pos,
                           input logic [IN_VAL_W-1:0] val,
                           input logic [POS_W-1:0] first, input logic [POS_W-1:0] last);
    logic [IN_DATA_W-1:0] word;
    int unsigned          gap;
    word = '0;
    word[POS_LSB   +: POS_W]    = pos;
    word[VAL_LSB   +: IN_VAL_W] = val;
    word[FIRST_LSB +: POS_W]    = first;
    word[LAST_LSB  +: POS_W]    = last;
    if (burst_left == 0) begin
      gap = 0;
      if (idle_on)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = idle_on ? $urandom_range(1, 16) : 64;
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    tracker.take_item(op, pos, val, first, last);
    burst_left--;
  endtask

  // Drop tvalid, wait for every outstanding query to come back, then let any update
  // still walking the tree finish.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // Write element_count on an idle block, then read it back.
  task automatic load_element_count(input logic [POS_W-1:0] count);
    logic [CFG_DATA_W-1:0] readback;
    wait_idle();
    cfg_transfer(1'b1, CFG_DATA_W'(count), readback);
    tracker.set_count(count);
    cfg_transfer(1'b0, '0, readback);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== CFG_DATA_W'(count)) begin
      $display("%0t: element_count readback, expected %0d, actual %0d", $time, count, readback);
      tracker.error_count++;
    end
  endtask

  // Mostly well-formed transactions inside the positions in use; the rest span the
  // whole field range so out-of-range updates and clipped queries show up.
  task automatic random_item();
    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    first;
    logic [POS_W-1:0]    last;
    logic [IN_VAL_W-1:0] val;
    int unsigned         top;
    int unsigned         roll;
    top  = tracker.positions_in_use();
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       val = IN_VAL_W'($urandom_range(0, 15));
      1:       val = ($urandom_range(0, 1) == 0) ? '0 : '1;
      default: val = IN_VAL_W'($urandom());
    endcase
    if (top != 0 && roll < 85) begin
      pos   = POS_W'($urandom_range(1, top));
      first = POS_W'($urandom_range(1, top));
      // narrow windows catch single leaves and sibling pairs
      last  = (roll < 20) ? first + POS_W'($urandom_range(0, 3))
                          : POS_W'($urandom_range(first, top));
    end else begin
      pos   = POS_W'($urandom_range(0, POS_ALL));
      first = POS_W'($urandom_range(0, POS_ALL));
      last  = POS_W'($urandom_range(0, POS_ALL));
    end
    send_item(($urandom_range(0, 1) == 1) ? OP_QUERY : OP_UPDATE, pos, val, first, last);
  endtask

  function automatic logic [POS_W-1:0] phase_count(int ph);
    case (ph)
      0:       return POS_W'(LEAF_COUNT);
      1:       return POS_W'(1);
      2:       return POS_W'(POS_ALL);
      3:       return POS_W'(0);
      4:       return POS_W'($urandom_range(2, LEAF_COUNT - 1));
      5:       return POS_W'(LEAF_COUNT + 1);
      6:       return POS_W'(2);
      7:       return POS_W'($urandom_range(3, LEAF_COUNT - 1));
      default: return POS_W'(LEAF_COUNT);
    endcase
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] readback;
    logic [POS_W-1:0]      count;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // the register must come up at its reset value
    cfg_transfer(1'b0, '0, readback);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== CFG_DATA_W'(ELEMENT_COUNT_RESET)) begin
      $display("%0t: element_count after reset, expected %0d, actual %0d",
               $time, ELEMENT_COUNT_RESET, readback);
      tracker.error_count++;
    end

    // Directed: field extremes, ignored updates, clipping and empty ranges.
    send_item(OP_UPDATE, 11'd1,    31'h7FFF_FFFF, 11'd0, 11'd0);
    send_item(OP_UPDATE, 11'd1024, 31'd5,         11'd0, 11'd0);
    send_item(OP_UPDATE, 11'd0,    31'd77,        11'd0, 11'd0);
    send_item(OP_UPDATE, 11'd2047, 31'd99,        11'd0, 11'd0);
    send_item(OP_UPDATE, 11'd1025, 31'd98,        11'd0, 11'd0);
    send_item(OP_UPDATE, 11'd512,  31'd1234,      11'd0, 11'd0);
    send_item(OP_QUERY,  11'd0,    31'd0,         11'd1,    11'd1024);
    send_item(OP_QUERY,  11'd0,    31'd0,         11'd0,    11'd2047);
    send_item(OP_QUERY,  11'd0,    31'd0,         11'd1024, 11'd1024);
    send_item(OP_QUERY,  11'd0,    31'd0,         11'd2,    11'd1023);
    send_item(OP_QUERY,  11'd0,    31'd0,         11'd600,  11'd3);
    send_item(OP_QUERY,  11'd0,    31'd0,         11'd513,  11'd1023);
    send_item(OP_UPDATE, 11'd1,    31'd0,         11'd0, 11'd0);
    send_item(OP_QUERY,  11'd0,    31'd0,         11'd1,    11'd1);
    send_item(OP_UPDATE, 11'd1023, 31'h2AAA_AAAA, 11'd0, 11'd0);
    send_item(OP_UPDATE, 11'd1024, 31'h5555_5555, 11'd0, 11'd0);
    send_item(OP_QUERY,  11'd0,    31'd0,         11'd1023, 11'd1024);
    send_item(OP_QUERY,  11'd0,    31'd0,         11'd0,    11'd0);

    // zero count: nothing reachable, updates dropped
    load_element_count(11'd0);
    send_item(OP_UPDATE, 11'd1,    31'd9,         11'd0, 11'd0);
    send_item(OP_QUERY,  11'd0,    31'd0,         11'd0,    11'd2047);
    // count above capacity acts as capacity; stored values are visible again
    load_element_count(11'd2047);
    send_item(OP_QUERY,  11'd0,    31'd0,         11'd1,    11'd2047);
    // lowered count hides the upper leaves
    load_element_count(11'd1);
    send_item(OP_UPDATE, 11'd2,    31'd3,         11'd0, 11'd0);
    send_item(OP_UPDATE, 11'd1,    31'd42,        11'd0, 11'd0);
    send_item(OP_QUERY,  11'd0,    31'd0,         11'd1,    11'd2047);

    // Random phases, one count setting each; run the first without any idling.
    for (int ph = 0; ph < 9; ph++) begin
      count = phase_count(ph);
      load_element_count(count);
      idle_on = (ph != 0);
      repeat ((count == 0) ? 30 : PHASE_ITEMS) random_item();
    end

    wait_idle();
    if (tracker.error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
hdl/rmst_pkg.sv
hdl/rmst_useq.sv
hdl/rmst_datapath.sv
hdl/range_max_segment_tree_unit.sv
tb/range_max_tracker_pkg.sv
tb/range_max_segment_tree_unit_test.sv
